[hw/rtl/ukvt_pkg.sv]
// ukvt_pkg: shared types and constants of the unsorted key/value table
// holds the item structs, command and status codes and the queue depth
// no dependencies
package ukvt_pkg;

    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int COUNT_OUT_BITS = 5;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef logic [COUNT_OUT_BITS-1:0] t_count_out;

    typedef struct packed {
        logic [1:0]            command;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  replace;
    } t_in_item;

    typedef struct packed {
        logic                  flag;
        logic [VALUE_BITS-1:0] value_out;
        logic [1:0]            status;
        t_count_out            entry_count_out;
    } t_out_item;

    // decoded command as it travels from the front to the back
    typedef struct packed {
        t_cmd                  cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  replace;
    } t_job;

endpackage

[hw/rtl/ukvt_ram.sv]
// ukvt_ram: generic single write port, single read port ram
// registered read data, no reset on contents
// no dependencies
module ukvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ukvt_front.sv]
// ukvt_front: accepts input items, decodes the command and queues the job
// short register queue that lets the back stall independently
// depends on ukvt_pkg
module ukvt_front
    import ukvt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_job_valid,
    input  logic     i_job_pop,
    output t_job     o_job
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_job           r_q [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           push;
    t_job           job_in;

    // decode of the raw item
    always_comb begin
        job_in.cmd     = t_cmd'(i_in_item.command);
        job_in.key     = i_in_item.key;
        job_in.value   = i_in_item.value;
        job_in.replace = i_in_item.replace;
    end

    assign o_in_stall  = (r_cnt == QCW'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QAW'(1);
        end
        if (i_job_pop) begin
            n_rp = (r_rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QAW'(1);
        end
        case ({push, i_job_pop})
            2'b10:   n_cnt = r_cnt + QCW'(1);
            2'b01:   n_cnt = r_cnt - QCW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule

[hw/rtl/ukvt_back.sv]
// ukvt_back: executes queued jobs against the key and value rams
// pipelined linear search, shift-down on remove, registered result
// depends on ukvt_pkg and ukvt_ram
module ukvt_back
    import ukvt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_pop,
    input  t_job      i_job,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_APPEND,
        S_REPLACE
    } t_state;

    t_state          r_state, n_state;
    t_job            r_job, n_job;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ridx, n_ridx;
    logic [CW-1:0]   r_cidx, n_cidx;
    logic            r_cv, n_cv;
    logic [CW-1:0]   r_pos, n_pos;
    logic            r_ovalid, n_ovalid;
    t_out_item       r_out, n_out;

    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic                  key_we, val_we;
    logic [AW-1:0]         waddr;
    logic [KEY_BITS-1:0]   wkey;
    logic [VALUE_BITS-1:0] wval;
    logic [CW-1:0]         cidx_prev, cidx_next, ridx_inc;
    logic                  more, scan_done, found;
    logic                  fin, fin_flag;
    t_status               fin_status;
    logic [VALUE_BITS-1:0] fin_vout;

    ukvt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (wkey),
        .i_raddr (r_ridx[AW-1:0]),
        .o_rdata (key_rdata)
    );

    ukvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (wval),
        .i_raddr (r_ridx[AW-1:0]),
        .o_rdata (val_rdata)
    );

    assign ridx_inc  = r_ridx + CW'(1);
    assign cidx_prev = r_cidx - CW'(1);
    assign cidx_next = r_cidx + CW'(1);
    assign more      = (r_ridx < r_count);
    assign scan_done = !r_cv && (r_ridx == r_count);
    assign found     = r_cv && (key_rdata == r_job.key);

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_count    = r_count;
        n_ridx     = r_ridx;
        n_cidx     = r_cidx;
        n_cv       = r_cv;
        n_pos      = r_pos;
        n_ovalid   = r_ovalid && i_out_stall;
        n_out      = r_out;
        o_job_pop  = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        waddr      = r_count[AW-1:0];
        wkey       = r_job.key;
        wval       = r_job.value;
        fin        = 1'b0;
        fin_flag   = 1'b0;
        fin_status = ST_OK;
        fin_vout   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_job_valid && !r_ovalid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_ridx    = '0;
                    n_cv      = 1'b0;
                    n_state   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // one read issued per cycle, compared on the next
                n_cv   = more;
                n_cidx = r_ridx;
                if (more) begin
                    n_ridx = ridx_inc;
                end
                if (found) begin
                    n_pos = r_cidx;
                    case (r_job.cmd)
                        CMD_INSERT: begin
                            if (r_job.replace) begin
                                n_state = S_REPLACE;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            n_ridx  = cidx_next;
                            n_cv    = 1'b0;
                            n_state = S_SHIFT;
                        end
                        CMD_FIND: begin
                            fin      = 1'b1;
                            fin_flag = 1'b1;
                        end
                        CMD_READ: begin
                            fin      = 1'b1;
                            fin_flag = 1'b1;
                            fin_vout = val_rdata;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end else if (scan_done) begin
                    case (r_job.cmd)
                        CMD_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        CMD_READ: begin
                            fin        = 1'b1;
                            fin_status = ST_ABSENT;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // read entry j, write it to j-1 on the next cycle
                n_cv   = more;
                n_cidx = r_ridx;
                if (more) begin
                    n_ridx = ridx_inc;
                end
                if (r_cv) begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                    waddr  = cidx_prev[AW-1:0];
                    wkey   = key_rdata;
                    wval   = val_rdata;
                end
                if (scan_done) begin
                    n_count  = r_count - CW'(1);
                    fin      = 1'b1;
                    fin_flag = 1'b1;
                end
            end
            S_APPEND: begin
                key_we   = 1'b1;
                val_we   = 1'b1;
                waddr    = r_count[AW-1:0];
                n_count  = r_count + CW'(1);
                fin      = 1'b1;
                fin_flag = 1'b1;
            end
            S_REPLACE: begin
                val_we = 1'b1;
                waddr  = r_pos[AW-1:0];
                fin    = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state               = S_IDLE;
            n_ovalid              = 1'b1;
            n_out.flag            = fin_flag;
            n_out.value_out       = fin_vout;
            n_out.status          = fin_status;
            n_out.entry_count_out = t_count_out'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cv     <= n_cv;
            r_ovalid <= n_ovalid;
        end
        r_job  <= n_job;
        r_ridx <= n_ridx;
        r_cidx <= n_cidx;
        r_pos  <= n_pos;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

[hw/rtl/unsorted_key_value_table.sv]
// unsorted_key_value_table: linear-search key/value table
// the back finishes one item before it takes the next; the front queues further
// items meanwhile, and the search reads one entry at a time through the single read port
// sync active-low reset empties the table and the queue; rams are not cleared
// depends on ukvt_pkg, ukvt_front, ukvt_back, ukvt_ram
module unsorted_key_value_table
    import ukvt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // command items in
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    // result items out
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // front to back job channel
    logic job_valid;
    logic job_pop;
    t_job job;

    // front: decodes each item and holds up to two jobs, so the input side
    // keeps accepting while the back works or a result waits to be taken
    ukvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job)
    );

    // back: one job at a time
    //   search streams the key and value rams from entry 0, one address per
    //   cycle, compare in the cycle after the read
    //   remove shifts later entries down, read of j overlapped with write of j-1
    //   insert of a new key appends at the fill count; replace rewrites in place
    // entries at or above the fill count are never compared or returned, so the rams need
    // no clearing after reset
    // the result register is only loaded when empty, so a stalled result holds
    ukvt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (job),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[verif/unsorted_key_value_table_test.sv]
// unsorted_key_value_table_test: self-checking bench for the linear-search key/value table
// drives command items with random gaps and stalls, predicts every result in a local table copy
// depends on ukvt_pkg and unsorted_key_value_table
`timescale 1ns / 100ps

module unsorted_key_value_table_test;
    import ukvt_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_OPS  = 2000;
    localparam int POOL_SIZE   = 24;
    localparam int DRAIN_CYCLES = 40;
    // limit on simulated cycles, set with a wide margin over the worst case per item
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    unsorted_key_value_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // local copy of the table contents, updated as each item is accepted
    logic [KEY_BITS-1:0]   kv_keys [CAPACITY];
    logic [VALUE_BITS-1:0] kv_vals [CAPACITY];
    int                    kv_count = 0;

    // results still owed by the block, oldest first
    t_out_item pending_results [$];

    // key pool for random traffic, small enough that hits and a full table are common
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

    int  errors = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  full_rejects = 0;
    int  peak_count = 0;
    int  stall_left = 0;
    // when low, neither side inserts gaps or stalls
    bit  idle_on = 1'b1;

    // ---------------------------------------------------------------
    // prediction: apply one command item to the local table
    // ---------------------------------------------------------------
    function automatic t_out_item table_apply(input t_in_item it);
        t_out_item r;
        int        pos;
        logic      present;
        r   = '0;
        pos = kv_count;
        // linear search from entry 0, first match wins
        for (int i = 0; i < kv_count; i++) begin
            if (kv_keys[i] == it.key) begin
                pos = i;
                break;
            end
        end
        present = (pos < kv_count);
        case (t_cmd'(it.command))
            CMD_INSERT: begin
                if (present) begin
                    // existing key: overwrite only on replace, never flagged
                    if (it.replace)
                        kv_vals[pos] = it.value;
                end else if (kv_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    kv_keys[kv_count] = it.key;
                    kv_vals[kv_count] = it.value;
                    kv_count++;
                    r.flag = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (present) begin
                    // close the gap so the array stays packed
                    for (int i = pos; i + 1 < kv_count; i++) begin
                        kv_keys[i] = kv_keys[i + 1];
                        kv_vals[i] = kv_vals[i + 1];
                    end
                    kv_count--;
                    r.flag = 1'b1;
                end
            end
            CMD_FIND: begin
                r.flag = present;
            end
            CMD_READ: begin
                if (present) begin
                    r.flag      = 1'b1;
                    r.value_out = kv_vals[pos];
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            default: begin
            end
        endcase
        r.entry_count_out = t_count_out'(kv_count);
        if (r.status == ST_FULL)
            full_rejects++;
        if (kv_count > peak_count)
            peak_count = kv_count;
        return r;
    endfunction

    function automatic t_in_item make_op(input t_cmd cmd, input logic [KEY_BITS-1:0] key,
                                         input logic [VALUE_BITS-1:0] value,
                                         input logic replace);
        t_in_item it;
        it.command = cmd;
        it.key     = key;
        it.value   = value;
        it.replace = replace;
        return it;
    endfunction

    // ---------------------------------------------------------------
    // sender: one item per call, entered and left at a falling edge
    // ---------------------------------------------------------------
    task automatic send_op(input t_in_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        // valid only drops when a real gap follows, so it never toggles within a step
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  = it;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (o_in_stall);
        // accepted at this edge: the result is owed from now on
        pending_results.push_back(table_apply(it));
        items_sent++;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // result side: stall drawn afresh after every result taken
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_stall <= (stall_left > 0);
    end

    task automatic compare_result(input t_out_item got);
        t_out_item want;
        bit        bad;
        if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        bad  = 1'b0;
        if (got.flag !== want.flag) begin
            $display("%0t ns: flag mismatch, expected %0b, actual %0b",
                     $time, want.flag, got.flag);
            bad = 1'b1;
        end
        if (got.value_out !== want.value_out) begin
            $display("%0t ns: value_out mismatch, expected %h, actual %h",
                     $time, want.value_out, got.value_out);
            bad = 1'b1;
        end
        if (got.status !== want.status) begin
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            bad = 1'b1;
        end
        if (got.entry_count_out !== want.entry_count_out) begin
            $display("%0t ns: entry_count_out mismatch, expected %0d, actual %0d",
                     $time, want.entry_count_out, got.entry_count_out);
            bad = 1'b1;
        end
        if (bad)
            errors++;
    endtask

    // stall counter lives here only; one stalled cycle is used up per edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            compare_result(o_out_item);
            results_seen++;
            stall_left = idle_on ? $urandom_range(0, 9) : 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("[unsorted_key_value_table] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    // lookups on an empty table
    task automatic test_empty_table();
        send_op(make_op(CMD_READ, '0, '1, 1'b1));
        send_op(make_op(CMD_REMOVE, '1, '0, 1'b0));
    endtask

    // extreme keys and values, duplicate insert with and without replace
    task automatic test_insert_replace();
        send_op(make_op(CMD_INSERT, '0, '0, 1'b0));
        send_op(make_op(CMD_INSERT, '1, '1, 1'b1));
        send_op(make_op(CMD_INSERT, '0, 32'ha5a5_5a5a, 1'b0));
        send_op(make_op(CMD_READ, '0, '0, 1'b0));
        send_op(make_op(CMD_INSERT, '0, '1, 1'b1));
        send_op(make_op(CMD_READ, '0, '0, 1'b0));
        send_op(make_op(CMD_FIND, '1, '0, 1'b0));
    endtask

    // fill to capacity, then a new key must bounce while an existing one still updates
    task automatic test_full_table();
        for (int i = 1; i <= CAPACITY - 2; i++)
            send_op(make_op(CMD_INSERT, KEY_BITS'(i) * 32'h0101_0101,
                            $urandom(), 1'($urandom())));
        send_op(make_op(CMD_INSERT, 32'h1234_5678, $urandom(), 1'b0));
        send_op(make_op(CMD_INSERT, '1, 32'h0f0f_0f0f, 1'b1));
    endtask

    // removal at the front, the back and the middle, then read a shifted entry
    task automatic test_remove_shift();
        send_op(make_op(CMD_REMOVE, '0, '0, 1'b0));
        send_op(make_op(CMD_REMOVE, KEY_BITS'(CAPACITY - 2) * 32'h0101_0101, '0, 1'b0));
        send_op(make_op(CMD_REMOVE, 32'h0505_0505, '0, 1'b0));
        send_op(make_op(CMD_READ, 32'h0909_0909, '0, 1'b0));
    endtask

    // ---------------------------------------------------------------
    // random traffic: alternating fill and drain phases over a small key pool
    // ---------------------------------------------------------------
    task automatic test_random_traffic();
        t_in_item it;
        int       pick;
        int       ins_w;
        int       rem_w;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        for (int n = 0; n < RANDOM_OPS; n++) begin
            // eight phases; odd ones drain, and some run with no gaps at all
            if (n % (RANDOM_OPS / 8) == 0)
                idle_on = ((n / (RANDOM_OPS / 8)) % 3) != 2;
            if (((n / (RANDOM_OPS / 8)) % 2) == 0) begin
                ins_w = 50;
                rem_w = 15;
            end else begin
                ins_w = 15;
                rem_w = 50;
            end
            pick = $urandom_range(0, 99);
            if (pick < ins_w)
                it.command = CMD_INSERT;
            else if (pick < ins_w + rem_w)
                it.command = CMD_REMOVE;
            else if (pick < ins_w + rem_w + 15)
                it.command = CMD_FIND;
            else
                it.command = CMD_READ;
            // mostly pool keys so hits happen, some fresh keys as misses
            if ($urandom_range(0, 99) < 85)
                it.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                it.key = $urandom();
            it.value   = $urandom();
            it.replace = 1'($urandom());
            send_op(it);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_insert_replace();
        test_full_table();
        test_remove_shift();
        test_random_traffic();
        i_in_valid = 1'b0;

        // wait out every owed result, then watch a little longer for strays
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d command items sent, %0d results checked, %0d mismatching",
                 items_sent, results_seen, errors);
        $display("table filled to %0d entries, %0d inserts refused as full",
                 peak_count, full_rejects);
        if (errors == 0)
            $display("[unsorted_key_value_table] OK");
        else
            $display("[unsorted_key_value_table] ERROR");
        $finish;
    end

endmodule
